[hw/rtl/assert_macros.svh]
// Assertion macros included by the top-level RTL file, which carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/mpct_pkg.sv]
// Package with the constants shared by the mouse packet cursor tracker.
package mpct_pkg;

    localparam int FIELD_BITS     = 12;
    localparam int DELTA_BITS     = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int BYTE_IDX_BITS  = 2;
    localparam int STORE_DEPTH    = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLED = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_LIMIT = 2'd2;

    localparam logic [BYTE_IDX_BITS-1:0] BYTE_FLAGS = 2'd0;
    localparam logic [BYTE_IDX_BITS-1:0] BYTE_DX    = 2'd1;
    localparam logic [BYTE_IDX_BITS-1:0] BYTE_DY    = 2'd2;
    localparam logic [BYTE_IDX_BITS-1:0] BYTE_WHEEL = 2'd3;

    localparam int FLAG_LEFT_BIT  = 0;
    localparam int FLAG_RIGHT_BIT = 1;

    localparam int X_LIMIT_RESET = 319;
    localparam int Y_LIMIT_RESET = 199;
    localparam int X_POS_RESET   = 160;
    localparam int Y_POS_RESET   = 100;

    typedef logic [DELTA_BITS-1:0] byte_t;

endpackage

[hw/rtl/mouse_packet_cursor_tracker_top.sv]
// Top level of the mouse packet cursor tracker: packet assembly, cursor update and result register.
// A result is registered and appears in the cycle after the transfer of the fourth packet byte.
// One byte per cycle unless in_stall holds it; the cursor add and clamp finish in the cycle of that transfer.
// While a result waits, the first three bytes of the next packet are still taken.
// Reset clears the packet position and result valid, loads the cursor to 160,100,
// the limits to 319,199 and leaves the block disabled.
module mouse_packet_cursor_tracker_top #(
    parameter int COORD_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [mpct_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [mpct_pkg::FIELD_BITS-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [mpct_pkg::DELTA_BITS-1:0]        rx_byte,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [mpct_pkg::FIELD_BITS-1:0]        cursor_x,
    output logic [mpct_pkg::FIELD_BITS-1:0]        cursor_y,
    output logic                                   left_pressed,
    output logic                                   right_pressed,
    output logic signed [mpct_pkg::DELTA_BITS-1:0] wheel_delta
);
    import mpct_pkg::*;

    `include "assert_macros.svh"

    logic                     enabled_reg;
    logic [COORD_BITS-1:0]    x_limit_reg;
    logic [COORD_BITS-1:0]    y_limit_reg;
    logic [BYTE_IDX_BITS-1:0] byte_index_reg;
    byte_t                    store_reg [STORE_DEPTH];
    logic [COORD_BITS-1:0]    pos_x_reg;
    logic [COORD_BITS-1:0]    pos_y_reg;
    logic [COORD_BITS-1:0]    pos_x_next;
    logic [COORD_BITS-1:0]    pos_y_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     left_reg;
    logic                     right_reg;
    byte_t                    wheel_reg;
    logic                     take;
    logic                     last_byte;
    logic                     packet_done;

    assign last_byte   = (byte_index_reg == BYTE_WHEEL);
    assign in_stall    = out_valid_reg && out_stall && enabled_reg && last_byte;
    assign take        = in_valid && !in_stall && enabled_reg;
    assign packet_done = take && last_byte;

    mpct_axis_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step_x (
        .pos      (pos_x_reg),
        .delta    (store_reg[BYTE_DX]),
        .subtract (1'b0),
        .limit    (x_limit_reg),
        .next_pos (pos_x_next)
    );

    mpct_axis_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step_y (
        .pos      (pos_y_reg),
        .delta    (store_reg[BYTE_DY]),
        .subtract (1'b1),
        .limit    (y_limit_reg),
        .next_pos (pos_y_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            x_limit_reg <= COORD_BITS'(X_LIMIT_RESET);
            y_limit_reg <= COORD_BITS'(Y_LIMIT_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLED: enabled_reg <= cfg_data[0];
                REG_X_LIMIT: x_limit_reg <= COORD_BITS'(cfg_data);
                REG_Y_LIMIT: y_limit_reg <= COORD_BITS'(cfg_data);
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= BYTE_FLAGS;
            pos_x_reg      <= COORD_BITS'(X_POS_RESET);
            pos_y_reg      <= COORD_BITS'(Y_POS_RESET);
        end
        else if (take)
        begin
            byte_index_reg <= byte_index_reg + BYTE_IDX_BITS'(1);
            if (last_byte)
            begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
        end
    end

    // The first three bytes of a packet are held until the fourth arrives.
    always_ff @(posedge clk)
    begin
        if (take && !last_byte)
        begin
            store_reg[byte_index_reg] <= rx_byte;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (packet_done)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Button bits and wheel are copied out because the store refills during a stall.
    always_ff @(posedge clk)
    begin
        if (packet_done)
        begin
            left_reg  <= store_reg[BYTE_FLAGS][FLAG_LEFT_BIT];
            right_reg <= store_reg[BYTE_FLAGS][FLAG_RIGHT_BIT];
            wheel_reg <= rx_byte;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_x      = FIELD_BITS'(pos_x_reg);
    assign cursor_y      = FIELD_BITS'(pos_y_reg);
    assign left_pressed  = left_reg;
    assign right_pressed = right_reg;
    assign wheel_delta   = $signed(wheel_reg);

    `ASSERT_NEXT(a_done_gives_result, packet_done, out_valid_reg)
    `ASSERT_NEXT(a_held_result_keeps_cursor, out_valid_reg && out_stall,
                 $stable(pos_x_reg) && $stable(pos_y_reg))
    `ASSERT_SAME(a_stall_only_on_last_byte, in_stall, last_byte && enabled_reg)

endmodule

[hw/rtl/mpct_axis_step.sv]
// Adds or subtracts a signed byte delta to one cursor coordinate and clamps it to 0..limit.
module mpct_axis_step #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] pos,
    input  mpct_pkg::byte_t       delta,
    input  logic                  subtract,
    input  logic [COORD_BITS-1:0] limit,
    output logic [COORD_BITS-1:0] next_pos
);
    import mpct_pkg::*;

    logic signed [COORD_BITS+1:0] pos_s;
    logic signed [COORD_BITS+1:0] delta_s;
    logic signed [COORD_BITS+1:0] sum;

    assign pos_s   = $signed({2'b00, pos});
    assign delta_s = $signed({{(COORD_BITS+2-DELTA_BITS){delta[DELTA_BITS-1]}}, delta});
    assign sum     = subtract ? (pos_s - delta_s) : (pos_s + delta_s);

    always_comb
    begin
        priority if (sum[COORD_BITS+1])
        begin
            next_pos = '0;
        end
        else if (sum[COORD_BITS:0] > {1'b0, limit})
        begin
            next_pos = limit;
        end
        else
        begin
            next_pos = sum[COORD_BITS-1:0];
        end
    end

endmodule

[test/mpct_tb_pkg.sv]
// Cursor report type and scoreboard class for the mouse packet cursor tracker bench.
package mpct_tb_pkg;
    import mpct_pkg::*;

    typedef struct packed {
        logic [FIELD_BITS-1:0]        x;
        logic [FIELD_BITS-1:0]        y;
        logic                         left;
        logic                         right;
        logic signed [DELTA_BITS-1:0] wheel;
    } cursor_report_t;

    class cursor_tracker_sb;
        bit                    enabled;
        logic [FIELD_BITS-1:0] x_limit;
        logic [FIELD_BITS-1:0] y_limit;
        logic [FIELD_BITS-1:0] pos_x;
        logic [FIELD_BITS-1:0] pos_y;
        int unsigned           byte_pos;
        byte_t                 packet[STORE_DEPTH];
        cursor_report_t        expected_reports[$];
        int unsigned           errors;
        int unsigned           reports_seen;
        int unsigned           bytes_taken;
        int unsigned           bytes_dropped;

        function new();
            enabled       = 1'b0;
            x_limit       = FIELD_BITS'(X_LIMIT_RESET);
            y_limit       = FIELD_BITS'(Y_LIMIT_RESET);
            pos_x         = FIELD_BITS'(X_POS_RESET);
            pos_y         = FIELD_BITS'(Y_POS_RESET);
            byte_pos      = 0;
            errors        = 0;
            reports_seen  = 0;
            bytes_taken   = 0;
            bytes_dropped = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] reg_index,
                                logic [FIELD_BITS-1:0] value);
            case (reg_index)
                REG_ENABLED: enabled = value[0];
                REG_X_LIMIT: x_limit = value;
                REG_Y_LIMIT: y_limit = value;
                default: ;
            endcase
        endfunction

        function logic [FIELD_BITS-1:0] clamp_to_limit(int v, logic [FIELD_BITS-1:0] limit);
            if (v < 0)
                return '0;
            if (v > int'(limit))
                return limit;
            return FIELD_BITS'(v);
        endfunction

        // Bytes are dropped while disabled; the fourth byte of a packet moves the cursor.
        function void take_byte(byte_t value);
            cursor_report_t rep;
            int             nx;
            int             ny;
            if (!enabled)
            begin
                bytes_dropped++;
                return;
            end
            bytes_taken++;
            if (byte_pos < STORE_DEPTH)
            begin
                packet[byte_pos] = value;
                byte_pos++;
                return;
            end
            byte_pos  = 0;
            nx        = int'(pos_x) + int'($signed(packet[BYTE_DX]));
            ny        = int'(pos_y) - int'($signed(packet[BYTE_DY]));
            pos_x     = clamp_to_limit(nx, x_limit);
            pos_y     = clamp_to_limit(ny, y_limit);
            rep.x     = pos_x;
            rep.y     = pos_y;
            rep.left  = packet[BYTE_FLAGS][FLAG_LEFT_BIT];
            rep.right = packet[BYTE_FLAGS][FLAG_RIGHT_BIT];
            rep.wheel = $signed(value);
            expected_reports.push_back(rep);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        task flag_mismatch(string what);
            errors++;
            if (errors <= 25)
                $display("MISMATCH: %s", what);
        endtask

        task check_report(cursor_report_t got);
            cursor_report_t want;
            reports_seen++;
            if (expected_reports.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected cursor report x=%0d y=%0d", got.x, got.y));
                return;
            end
            want = expected_reports.pop_front();
            if (got.x !== want.x)
                flag_mismatch($sformatf("cursor_x got %0d want %0d", got.x, want.x));
            if (got.y !== want.y)
                flag_mismatch($sformatf("cursor_y got %0d want %0d", got.y, want.y));
            if (got.left !== want.left)
                flag_mismatch($sformatf("left_pressed got %b want %b", got.left, want.left));
            if (got.right !== want.right)
                flag_mismatch($sformatf("right_pressed got %b want %b", got.right, want.right));
            if (got.wheel !== want.wheel)
                flag_mismatch($sformatf("wheel_delta got %0d want %0d", got.wheel, want.wheel));
        endtask
    endclass

endpackage

[test/tb_top.sv]
// Self-checking bench for the mouse packet cursor tracker with random pacing and a long output hold.
module tb_top;
    import mpct_pkg::*;
    import mpct_tb_pkg::*;

    localparam int                        TOTAL_ITEMS      = 1050;
    localparam int                        QUIET_ITEMS      = 120;
    localparam int                        LONG_HOLD_CYCLES = 64;
    localparam int                        SETTLE_CYCLES    = 4;
    localparam int                        CYCLE_LIMIT      = 400000;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE        = 2'd3;

    typedef enum int {DRIFT_ANY, DRIFT_GROW, DRIFT_SHRINK, DRIFT_MAX} drift_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [CFG_INDEX_BITS-1:0]    cfg_index;
    logic [FIELD_BITS-1:0]        cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic [DELTA_BITS-1:0]        rx_byte;
    logic                         out_valid;
    logic                         out_stall;
    logic [FIELD_BITS-1:0]        cursor_x;
    logic [FIELD_BITS-1:0]        cursor_y;
    logic                         left_pressed;
    logic                         right_pressed;
    logic signed [DELTA_BITS-1:0] wheel_delta;

    cursor_tracker_sb sb;
    cursor_report_t   seen;
    int unsigned      cycle_count = 0;
    int unsigned      long_holds  = 0;
    int unsigned      phases;
    int unsigned      stim_bytes;
    int unsigned      slot;
    int unsigned      send_idle_pct;
    int unsigned      stall_pct;
    bit               long_hold_req;

    mouse_packet_cursor_tracker_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_x      (cursor_x),
        .cursor_y      (cursor_y),
        .left_pressed  (left_pressed),
        .right_pressed (right_pressed),
        .wheel_delta   (wheel_delta)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.take_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                seen.x     = cursor_x;
                seen.y     = cursor_y;
                seen.left  = left_pressed;
                seen.right = right_pressed;
                seen.wheel = wheel_delta;
                sb.check_report(seen);
            end
        end
    end

    // A requested long hold keeps the result side stalled so the block backs up into its input.
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
                long_holds++;
            end
            else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    task automatic push_byte(input byte_t value);
        if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] reg_index,
                             input logic [FIELD_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(reg_index, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_packet(input byte_t flags, input byte_t dx, input byte_t dy,
                               input byte_t wheel);
        push_byte(flags);
        push_byte(dx);
        push_byte(dy);
        push_byte(wheel);
        stim_bytes += 4;
    endtask

    task automatic push_noise(input int unsigned count);
        repeat (count) push_byte(byte_t'($urandom_range(0, 255)));
    endtask

    function automatic byte_t make_byte(int unsigned pos, drift_t drift);
        if (pos == BYTE_DX)
            case (drift)
                DRIFT_GROW:   return byte_t'($urandom_range(64, 127));
                DRIFT_SHRINK: return byte_t'($urandom_range(128, 192));
                DRIFT_MAX:    return 8'h7F;
                default:      return byte_t'($urandom_range(0, 255));
            endcase
        if (pos == BYTE_DY)
            case (drift)
                DRIFT_GROW:   return byte_t'($urandom_range(128, 192));
                DRIFT_SHRINK: return byte_t'($urandom_range(64, 127));
                DRIFT_MAX:    return 8'h80;
                default:      return byte_t'($urandom_range(0, 255));
            endcase
        return byte_t'($urandom_range(0, 255));
    endfunction

    task automatic send_run(input int unsigned count, input drift_t drift);
        repeat (count)
        begin
            push_byte(make_byte(slot, drift));
            slot = (slot + 1) % 4;
            stim_bytes++;
        end
    endtask

    function automatic logic [FIELD_BITS-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return FIELD_BITS'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        int unsigned n_packets;
        int unsigned extra;
        bit          quiet;
        drift_t      drift;
        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ENABLED;
        cfg_data      = '0;
        in_valid      = 1'b0;
        rx_byte       = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        long_hold_req = 1'b0;
        slot          = 0;
        stim_bytes    = 0;
        phases        = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The block comes out of reset disabled, so these bytes must vanish.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_noise(2);
        settle();
        write_reg(REG_ENABLED, 12'd1);

        send_idle_pct = 20;
        stall_pct     = 20;
        push_packet(8'h00, 8'h00, 8'h00, 8'h00);
        push_packet(8'hFF, 8'h7F, 8'h80, 8'h7F);
        push_packet(8'h01, 8'h7F, 8'h7F, 8'h80);
        push_packet(8'h02, 8'h80, 8'h7F, 8'hFF);
        push_packet(8'hC8, 8'h80, 8'h01, 8'h01);
        push_packet(8'h09, 8'h80, 8'hFF, 8'h00);
        settle();

        while (stim_bytes < TOTAL_ITEMS)
        begin
            quiet     = (stim_bytes + QUIET_ITEMS >= TOTAL_ITEMS);
            drift     = drift_t'($urandom_range(0, 2));
            n_packets = $urandom_range(3, 25);
            extra     = 0;
            case (phases)
                0:
                begin
                    write_reg(REG_X_LIMIT, '1);
                    write_reg(REG_Y_LIMIT, '1);
                    drift     = DRIFT_MAX;
                    n_packets = 36;
                end
                1:
                begin
                    write_reg(REG_X_LIMIT, FIELD_BITS'($urandom_range(0, 200)));
                    write_reg(REG_Y_LIMIT, FIELD_BITS'($urandom_range(0, 200)));
                end
                2:
                begin
                    write_reg(REG_X_LIMIT, '0);
                    write_reg(REG_Y_LIMIT, '0);
                end
                default:
                begin
                    write_reg(REG_X_LIMIT, pick_limit());
                    write_reg(REG_Y_LIMIT, pick_limit());
                    if ($urandom_range(0, 5) == 0)
                        write_reg(REG_SPARE, FIELD_BITS'($urandom));
                    if (!quiet && $urandom_range(0, 3) == 0)
                        extra = $urandom_range(1, 3);
                end
            endcase
            if (quiet)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            else if (phases == 4 || phases == 11)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
                long_hold_req = 1'b1;
            end
            else
            begin
                send_idle_pct = $urandom_range(0, 3) * 15;
                stall_pct     = $urandom_range(0, 3) * 15;
            end
            send_run(n_packets * 4 + extra, drift);
            settle();
            // A run that stopped inside a packet is paused, fed junk while disabled, then resumed.
            if (extra != 0)
            begin
                write_reg(REG_ENABLED, 12'd0);
                push_noise($urandom_range(2, 6));
                settle();
                write_reg(REG_ENABLED, {11'($urandom), 1'b1});
            end
            phases++;
        end

        settle();
        $display("Covered %0d tracked bytes, %0d dropped while disabled, %0d cursor reports.",
                 sb.bytes_taken, sb.bytes_dropped, sb.reports_seen);
        $display("Limit settings in %0d phases, zero and full scale included, %0d long holds.",
                 phases, long_holds);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[mouse_packet_cursor_tracker_top.f]
+incdir+hw/rtl
hw/rtl/mpct_pkg.sv
hw/rtl/mpct_axis_step.sv
hw/rtl/mouse_packet_cursor_tracker_top.sv
test/mpct_tb_pkg.sv
test/tb_top.sv
